/* hdl/hng_pkg.sv */
// ----------------------------------------------------------------------------
// hng_pkg
// shared types and constants of the heightmap normal generator
// ----------------------------------------------------------------------------
package hng_pkg;

  localparam int unsigned HEIGHT_W        = 16;
  localparam int unsigned DIFF_W          = 17;
  localparam int unsigned MAG_W           = 16;
  localparam int unsigned NORM_W          = 16;
  localparam int unsigned NORM_Y_W        = 15;
  localparam int unsigned COORD_W         = 7;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 8;
  localparam int unsigned MAX_COLUMNS_DEF = 128;
  localparam int unsigned ROW_LIMIT       = 128;
  localparam int unsigned COL_LIMIT       = 128;
  localparam int unsigned GRID_RESET      = 128;
  localparam int unsigned ONE_Q8_8        = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 8'd0,
    CFG_GRID_ROWS    = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic [NORM_Y_W-1:0]      y;
    logic signed [NORM_W-1:0] z;
  } hng_normal_t;

endpackage

/* hdl/heightmap_normal_generator.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// forward-difference unit normals of a raster heightmap, previous row in a
// line store, one shared normalizing unit
// ----------------------------------------------------------------------------
// a sample passes S_RDC, S_RDR, S_CALC and S_DISPATCH; each normal then goes
//   through the unit (S_WAIT) and S_PUT, which waits for a free output register,
//   up to three normals per sample before the next sample is taken; the unit
//   squares dx and dz in turn, then runs one 15-step search per component
// reset: grid size 128 x 128, counters and previous height cleared; the line
//   store is not cleared, row 0 rewrites it before its contents are used
module heightmap_normal_generator
  import hng_pkg::*;
#(
  parameter int unsigned MaxColumns = MAX_COLUMNS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [HEIGHT_W-1:0] height_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [NORM_W-1:0]   normal_x_o,
  output logic [NORM_Y_W-1:0]        normal_y_o,
  output logic signed [NORM_W-1:0]   normal_z_o,
  output logic [COORD_W-1:0]         vertex_column_o,
  output logic [COORD_W-1:0]         vertex_row_o,
  output logic                       final_normal_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AddrW    = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int unsigned ColLimit = (MaxColumns < COL_LIMIT) ? MaxColumns : COL_LIMIT;

  typedef enum logic [2:0] {
    S_IDLE, S_RDC, S_RDR, S_CALC, S_DISPATCH, S_WAIT, S_PUT
  } state_e;
  typedef enum logic [1:0] {JOB_UP, JOB_LEFT, JOB_LAST, JOB_END} job_e;

  state_e                      state_q;
  job_e                        job_q;
  logic [CFG_DATA_W-1:0]       grid_columns_q, grid_rows_q;
  logic [COORD_W-1:0]          col_cnt_q, row_cnt_q;
  logic signed [HEIGHT_W-1:0]  prev_height_q;
  logic signed [HEIGHT_W-1:0]  h_q, prev_q, c_q, rt_q;
  logic [COORD_W-1:0]          i_q, r_q;
  logic                        last_col_q, last_row_q;
  logic [COORD_W-1:0]          tag_col_q, tag_row_q;
  logic                        tag_fin_q;
  logic                        out_valid_q;
  hng_normal_t                 out_q;
  logic [COORD_W-1:0]          out_col_q, out_row_q;
  logic                        out_fin_q;

  logic [7:0]                  cols_eff, rows_eff;
  logic [COORD_W-1:0]          cur_col, cur_row;
  logic                        cur_last_col, cur_last_row;
  logic                        in_fire, cfg_fire, put_fire;
  logic                        job_need, unit_start, unit_done;
  logic signed [DIFF_W-1:0]    op_dx, op_dz;
  logic [COORD_W-1:0]          job_col, job_row;
  hng_normal_t                 unit_normal;
  logic [AddrW-1:0]            ram_raddr;
  logic [HEIGHT_W-1:0]         ram_rdata;

  always_comb begin
    if (grid_columns_q < 8'd2) begin
      cols_eff = 8'd2;
    end else if (grid_columns_q > 8'(ColLimit)) begin
      cols_eff = 8'(ColLimit);
    end else begin
      cols_eff = grid_columns_q;
    end
    if (grid_rows_q < 8'd2) begin
      rows_eff = 8'd2;
    end else if (grid_rows_q > 8'(ROW_LIMIT)) begin
      rows_eff = 8'(ROW_LIMIT);
    end else begin
      rows_eff = grid_rows_q;
    end
  end

  assign cur_col      = ({1'b0, col_cnt_q} >= cols_eff) ? COORD_W'(cols_eff - 8'd1) : col_cnt_q;
  assign cur_row      = ({1'b0, row_cnt_q} >= rows_eff) ? COORD_W'(rows_eff - 8'd1) : row_cnt_q;
  assign cur_last_col = ({1'b0, cur_col} == (cols_eff - 8'd1));
  assign cur_last_row = ({1'b0, cur_row} == (rows_eff - 8'd1));

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign put_fire    = (state_q == S_PUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    job_need = 1'b0;
    op_dx    = '0;
    op_dz    = '0;
    job_col  = i_q;
    job_row  = r_q;
    unique case (job_q)
      JOB_UP: begin
        job_need = (r_q != '0);
        op_dx    = DIFF_W'(c_q) - DIFF_W'(last_col_q ? c_q : rt_q);
        op_dz    = DIFF_W'(c_q) - DIFF_W'(h_q);
        job_row  = r_q - COORD_W'(1);
      end
      JOB_LEFT: begin
        job_need = last_row_q && (i_q != '0);
        op_dx    = DIFF_W'(prev_q) - DIFF_W'(h_q);
        job_col  = i_q - COORD_W'(1);
      end
      JOB_LAST: begin
        job_need = last_row_q && last_col_q;
      end
      default: begin
        job_need = 1'b0;
      end
    endcase
  end

  assign unit_start = (state_q == S_DISPATCH) && job_need;
  assign ram_raddr  = (state_q == S_RDC) ? AddrW'(i_q) : AddrW'({1'b0, i_q} + 8'd1);

  hng_ram #(
    .Width (HEIGHT_W),
    .Depth (MaxColumns)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_CALC),
    .waddr_i (AddrW'(i_q)),
    .wdata_i (h_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hng_norm_unit u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .dx_i     (op_dx),
    .dz_i     (op_dz),
    .done_o   (unit_done),
    .normal_o (unit_normal)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      job_q          <= JOB_UP;
      grid_columns_q <= CFG_DATA_W'(GRID_RESET);
      grid_rows_q    <= CFG_DATA_W'(GRID_RESET);
      col_cnt_q      <= '0;
      row_cnt_q      <= '0;
      prev_height_q  <= '0;
      h_q            <= '0;
      prev_q         <= '0;
      c_q            <= '0;
      rt_q           <= '0;
      i_q            <= '0;
      r_q            <= '0;
      last_col_q     <= 1'b0;
      last_row_q     <= 1'b0;
      tag_col_q      <= '0;
      tag_row_q      <= '0;
      tag_fin_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_fin_q      <= 1'b0;
    end else begin
      if (put_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        if (cfg_index_i == CFG_GRID_COLUMNS) begin
          grid_columns_q <= cfg_data_i;
          col_cnt_q      <= '0;
          row_cnt_q      <= '0;
        end else if (cfg_index_i == CFG_GRID_ROWS) begin
          grid_rows_q <= cfg_data_i;
          col_cnt_q   <= '0;
          row_cnt_q   <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            h_q           <= height_sample_i;
            prev_q        <= prev_height_q;
            i_q           <= cur_col;
            r_q           <= cur_row;
            last_col_q    <= cur_last_col;
            last_row_q    <= cur_last_row;
            prev_height_q <= height_sample_i;
            if (cur_last_col) begin
              col_cnt_q <= '0;
              row_cnt_q <= cur_last_row ? '0 : cur_row + COORD_W'(1);
            end else begin
              col_cnt_q <= cur_col + COORD_W'(1);
              row_cnt_q <= cur_row;
            end
            state_q <= S_RDC;
          end
        end
        S_RDC: begin
          state_q <= S_RDR;
        end
        S_RDR: begin
          c_q     <= ram_rdata;
          state_q <= S_CALC;
        end
        S_CALC: begin
          rt_q    <= ram_rdata;
          job_q   <= JOB_UP;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (job_q)
            JOB_UP:   job_q <= JOB_LEFT;
            JOB_LEFT: job_q <= JOB_LAST;
            default:  job_q <= JOB_END;
          endcase
          if (job_q == JOB_END) begin
            state_q <= S_IDLE;
          end else if (job_need) begin
            tag_col_q <= job_col;
            tag_row_q <= job_row;
            tag_fin_q <= (job_q == JOB_LAST);
            state_q   <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_fire) begin
            out_q     <= unit_normal;
            out_col_q <= tag_col_q;
            out_row_q <= tag_row_q;
            out_fin_q <= tag_fin_q;
            state_q   <= S_DISPATCH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign normal_x_o      = out_q.x;
  assign normal_y_o      = out_q.y;
  assign normal_z_o      = out_q.z;
  assign vertex_column_o = out_col_q;
  assign vertex_row_o    = out_row_q;
  assign final_normal_o  = out_fin_q;

endmodule

/* hdl/hng_ram.sv */
// ----------------------------------------------------------------------------
// hng_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hng_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/hng_norm_unit.sv */
// ----------------------------------------------------------------------------
// hng_norm_unit
// normalizes (dx, 1, dz) to q1.14 components, bit-serial rounded search
// with one shared squarer and one three-input accumulate per step
// ----------------------------------------------------------------------------
module hng_norm_unit
  import hng_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] dx_i,
  input  logic signed [DIFF_W-1:0] dz_i,
  output logic                     done_o,
  output hng_normal_t              normal_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_SQX, ST_SQZ, ST_SETUP, ST_ITER} state_e;
  typedef enum logic [1:0] {COMP_X, COMP_Y, COMP_Z} comp_e;

  function automatic logic [MAG_W-1:0] mag_f(logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  state_e                    state_q;
  comp_e                     comp_q;
  logic signed [DIFF_W-1:0]  dx_q, dz_q;
  logic [31:0]               sx_q;
  logic [33:0]               s_q;
  logic [61:0]               r_q;
  logic [61:0]               x_q;
  logic [67:0]               p_q;
  logic [63:0]               q2_q;
  logic [NORM_Y_W-1:0]       qv_q;
  logic [NORM_Y_W-1:0]       bit_q;
  logic                      done_q;
  hng_normal_t               res_q;

  logic signed [DIFF_W-1:0]  comp_val;
  logic [MAG_W-1:0]          mul_a;
  logic [31:0]               prod;
  logic [67:0]               trial;
  logic                      fits;
  logic [67:0]               p_sel;
  logic [67:0]               p_next;
  logic [NORM_Y_W-1:0]       q_fin;
  logic [NORM_W-1:0]         q_signed;

  always_comb begin
    unique case (comp_q)
      COMP_X:  comp_val = dx_q;
      COMP_Y:  comp_val = DIFF_W'(ONE_Q8_8);
      COMP_Z:  comp_val = dz_q;
      default: comp_val = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      ST_SQX:  mul_a = mag_f(dx_q);
      ST_SQZ:  mul_a = mag_f(dz_q);
      default: mul_a = mag_f(comp_val);
    endcase
  end

  assign prod   = mul_a * mul_a;
  // candidate (2t-1)^2 * s from the running terms
  assign trial  = {6'b0, x_q} + p_q + {4'b0, q2_q};
  assign fits   = !qv_q[NORM_Y_W-1] && (trial <= {6'b0, r_q});
  assign p_sel  = fits ? (p_q + {3'b0, q2_q, 1'b0}) : p_q;
  assign p_next = 68'($signed(p_sel) >>> 1);
  assign q_fin  = fits ? (qv_q | bit_q) : qv_q;
  assign q_signed = comp_val[DIFF_W-1] ? (NORM_W'(0) - {1'b0, q_fin}) : {1'b0, q_fin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comp_q  <= COMP_X;
      done_q  <= 1'b0;
      dx_q    <= '0;
      dz_q    <= '0;
      sx_q    <= '0;
      s_q     <= '0;
      r_q     <= '0;
      x_q     <= '0;
      p_q     <= '0;
      q2_q    <= '0;
      qv_q    <= '0;
      bit_q   <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            dx_q    <= dx_i;
            dz_q    <= dz_i;
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          sx_q    <= prod;
          state_q <= ST_SQZ;
        end
        ST_SQZ: begin
          s_q     <= {2'b0, sx_q} + 34'(ONE_Q8_8 * ONE_Q8_8) + {2'b0, prod};
          comp_q  <= COMP_X;
          state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          r_q     <= {prod, 30'b0};
          x_q     <= {28'b0, s_q};
          p_q     <= 68'd0 - {18'b0, s_q, 16'b0};
          q2_q    <= {s_q, 30'b0};
          qv_q    <= '0;
          bit_q   <= {1'b1, {(NORM_Y_W-1){1'b0}}};
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (fits) begin
            x_q <= trial[61:0];
          end
          p_q   <= p_next;
          q2_q  <= q2_q >> 2;
          qv_q  <= q_fin;
          bit_q <= bit_q >> 1;
          if (bit_q[0]) begin
            unique case (comp_q)
              COMP_X: begin
                res_q.x <= q_signed;
                comp_q  <= COMP_Y;
                state_q <= ST_SETUP;
              end
              COMP_Y: begin
                res_q.y <= q_fin;
                comp_q  <= COMP_Z;
                state_q <= ST_SETUP;
              end
              default: begin
                res_q.z <= q_signed;
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign normal_o = res_q;

endmodule
